FILE: design/mqrim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-queue ring index manager: shared definitions
// Sizes, operation and status codes, the request and response bundles
// passed between the top level and the queue table, and the pointer
// advance function.
// ----------------------------------------------------------------------------
package mqrim_pkg;

    // Number of ring queues under management (1 to 32).
    localparam int NUM_QUEUES = 32;

    // Index width into the per-queue stores.
    localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    // Fixed field widths of the item.
    localparam int OP_W     = 2;
    localparam int QUEUE_W  = 5;
    localparam int SLOT_W   = 8;
    localparam int STATUS_W = 3;

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_ACQUIRE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_POP     = 2'd2,
        OP_PUSH    = 2'd3
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_NO_FREE      = 3'd1,
        ST_NOT_ACQUIRED = 3'd2,
        ST_EMPTY        = 3'd3,
        ST_FULL         = 3'd4
    } status_t;

    // One operation presented to the queue table.
    typedef struct packed {
        logic               valid;
        op_t                op;
        logic [QUEUE_W-1:0] target_queue;
        logic [SLOT_W-1:0]  slot_count;
    } req_t;

    // The answer to one operation.
    typedef struct packed {
        status_t            status;
        logic [QUEUE_W-1:0] acquired_queue;
        logic [SLOT_W-1:0]  slot_index;
    } rsp_t;

    // Advance a ring pointer by one, wrapping to zero once it reaches the
    // slot count. A count of zero or one therefore always gives zero.
    function automatic logic [SLOT_W-1:0] advance(input logic [SLOT_W-1:0] ptr,
                                                  input logic [SLOT_W-1:0] size);
        logic [SLOT_W:0] incr;
        incr = {1'b0, ptr} + {{SLOT_W{1'b0}}, 1'b1};
        if (incr >= {1'b0, size}) begin
            return '0;
        end
        return incr[SLOT_W-1:0];
    endfunction

endpackage

FILE: design/mqrim_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-queue ring index manager: queue table
// Holds the occupancy map and, per queue, the slot count and the read and
// write pointers. Computes the response to one operation combinationally
// and updates the table at the clock edge on which the request is valid.
// ----------------------------------------------------------------------------
module mqrim_table (
    input  logic              aclk,
    input  logic              aresetn,
    input  mqrim_pkg::req_t   req,
    output mqrim_pkg::rsp_t   rsp
);

    // Table storage. Only the occupancy map is reset: an entry whose queue
    // is not occupied reads as zero, which matches a cleared entry.
    logic [mqrim_pkg::NUM_QUEUES-1:0] occ_reg;
    logic [mqrim_pkg::NUM_QUEUES-1:0] occ_next;
    logic [mqrim_pkg::SLOT_W-1:0]     size_reg [mqrim_pkg::NUM_QUEUES];
    logic [mqrim_pkg::SLOT_W-1:0]     rptr_reg [mqrim_pkg::NUM_QUEUES];
    logic [mqrim_pkg::SLOT_W-1:0]     wptr_reg [mqrim_pkg::NUM_QUEUES];

    logic                           in_range;
    logic [mqrim_pkg::QIDX_W-1:0]   qsel;
    logic                           sel_occ;
    logic [mqrim_pkg::SLOT_W-1:0]   sel_size;
    logic [mqrim_pkg::SLOT_W-1:0]   sel_rptr;
    logic [mqrim_pkg::SLOT_W-1:0]   sel_wptr;
    logic [mqrim_pkg::SLOT_W-1:0]   rptr_adv;
    logic [mqrim_pkg::SLOT_W-1:0]   wptr_adv;

    logic                           free_found;
    logic [mqrim_pkg::QIDX_W-1:0]   free_idx;

    logic                           acq_we;
    logic                           rptr_we;
    logic                           wptr_we;

    // Address decode and read of the addressed entry.
    always_comb begin
        in_range = {1'b0, req.target_queue}
                   < (mqrim_pkg::QUEUE_W + 1)'(mqrim_pkg::NUM_QUEUES);
        qsel     = req.target_queue[mqrim_pkg::QIDX_W-1:0];
        sel_occ  = in_range && occ_reg[qsel];
        sel_size = sel_occ ? size_reg[qsel] : '0;
        sel_rptr = sel_occ ? rptr_reg[qsel] : '0;
        sel_wptr = sel_occ ? wptr_reg[qsel] : '0;
        rptr_adv = mqrim_pkg::advance(sel_rptr, sel_size);
        wptr_adv = mqrim_pkg::advance(sel_wptr, sel_size);
    end

    // Priority encoder for the lowest free queue.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = mqrim_pkg::NUM_QUEUES - 1; i >= 0; i--) begin
            if (!occ_reg[i]) begin
                free_found = 1'b1;
                free_idx   = mqrim_pkg::QIDX_W'(i);
            end
        end
    end

    // Operation decode: response and table write enables.
    always_comb begin
        rsp.status         = mqrim_pkg::ST_OK;
        rsp.acquired_queue = '0;
        rsp.slot_index     = '0;
        occ_next           = occ_reg;
        acq_we             = 1'b0;
        rptr_we            = 1'b0;
        wptr_we            = 1'b0;
        unique case (req.op)
            mqrim_pkg::OP_ACQUIRE: begin
                if (free_found) begin
                    acq_we             = 1'b1;
                    occ_next[free_idx] = 1'b1;
                    rsp.acquired_queue = mqrim_pkg::QUEUE_W'(free_idx);
                end else begin
                    rsp.status = mqrim_pkg::ST_NO_FREE;
                end
            end
            mqrim_pkg::OP_RELEASE: begin
                if (sel_occ) begin
                    occ_next[qsel] = 1'b0;
                end else begin
                    rsp.status = mqrim_pkg::ST_NOT_ACQUIRED;
                end
            end
            mqrim_pkg::OP_POP: begin
                if (sel_rptr == sel_wptr) begin
                    rsp.status = mqrim_pkg::ST_EMPTY;
                end else begin
                    rptr_we        = 1'b1;
                    rsp.slot_index = sel_rptr;
                end
            end
            mqrim_pkg::OP_PUSH: begin
                if (wptr_adv == sel_rptr) begin
                    rsp.status = mqrim_pkg::ST_FULL;
                end else begin
                    wptr_we        = 1'b1;
                    rsp.slot_index = sel_wptr;
                end
            end
            default: begin
                rsp.status = mqrim_pkg::ST_OK;
            end
        endcase
    end

    // Occupancy map.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else if (req.valid) begin
            occ_reg <= occ_next;
        end
    end

    // Per-queue entries: an acquire loads the count and zeroes both pointers.
    always_ff @(posedge aclk) begin
        if (req.valid) begin
            if (acq_we) begin
                size_reg[free_idx] <= req.slot_count;
                rptr_reg[free_idx] <= '0;
                wptr_reg[free_idx] <= '0;
            end
            if (rptr_we) begin
                rptr_reg[qsel] <= rptr_adv;
            end
            if (wptr_we) begin
                wptr_reg[qsel] <= wptr_adv;
            end
        end
    end

endmodule

FILE: design/multi_queue_ring_index_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-queue ring index manager
// Keeps index bookkeeping for a set of ring-buffer queues: acquire, release,
// pop and push, each answered with one result item.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle: an input register feeds the queue table,
// whose answer is caught in the result register at the same edge that updates
// the table, so each item sees every earlier item's effect. Only a stalled
// result holds back the input side. No clearing pass is needed after reset.
module multi_queue_ring_index_manager (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [4:0] target queue, [12:5] slot_count, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] op

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [4:0] acquired_queue, [12:5] slot_index, rest zero
    output logic [2:0]  m_tuser    // [2:0] status
);

    logic                         in_valid_reg;
    mqrim_pkg::op_t               in_op_reg;
    logic [mqrim_pkg::QUEUE_W-1:0] in_queue_reg;
    logic [mqrim_pkg::SLOT_W-1:0]  in_count_reg;

    logic                         out_valid_reg;
    mqrim_pkg::rsp_t              out_rsp_reg;

    logic                         advance_stage;
    mqrim_pkg::req_t              req;
    mqrim_pkg::rsp_t              rsp;

    // The item in the input register moves on whenever the result register
    // is free or is being emptied.
    assign advance_stage = !out_valid_reg || m_tready;
    assign s_tready      = !in_valid_reg || advance_stage;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg    <= mqrim_pkg::op_t'(s_tuser[1:0]);
            in_queue_reg <= s_tdata[4:0];
            in_count_reg <= s_tdata[12:5];
        end
    end

    // Request to the queue table; it commits only when the result can move.
    always_comb begin
        req.valid        = in_valid_reg && advance_stage;
        req.op           = in_op_reg;
        req.target_queue = in_queue_reg;
        req.slot_count   = in_count_reg;
    end

    mqrim_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance_stage) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.valid) begin
            out_rsp_reg <= rsp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_rsp_reg.status;
    assign m_tdata  = {3'b000, out_rsp_reg.slot_index, out_rsp_reg.acquired_queue};

endmodule
